[design/fixed_weight_word_unrank_macros.svh]
// Assertion macros shared by the fixed-weight word unrank design.
`ifndef FIXED_WEIGHT_WORD_UNRANK_MACROS_SVH
`define FIXED_WEIGHT_WORD_UNRANK_MACROS_SVH

// Check a consequence in the same cycle, sampled on clock, off during reset.
`define FWWU_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Check a consequence in the following cycle, sampled on clock, off during reset.
`define FWWU_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/fwwu_pkg.sv]
// Shared types and constants for the fixed-weight word unrank block.
`default_nettype none

package fwwu_pkg;

   // Field and table widths
   localparam int MAX_WIDTH_DEF = 31;
   localparam int RANK_W        = 32;
   localparam int WORD_W        = 31;
   localparam int ENTRY_W       = 30;
   localparam int CFG_W         = 5;
   localparam int CSR_IDX_W     = 1;

   // Register indexes and reset values
   localparam logic [CSR_IDX_W-1:0] REG_WORD_WIDTH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_ONES_COUNT = 1'b1;
   localparam logic [CFG_W-1:0]     WORD_WIDTH_RST = 5'd6;
   localparam logic [CFG_W-1:0]     ONES_COUNT_RST = 5'd3;

   // Table read address selection
   localparam logic [1:0] ADDR_RANGE = 2'd0;
   localparam logic [1:0] ADDR_START = 2'd1;
   localparam logic [1:0] ADDR_SCAN  = 2'd2;

   // Commands from controller to datapath
   typedef struct packed {
      logic       fill_step;
      logic       load;
      logic [1:0] addr_sel;
      logic       scan;
      logic       finish_ok;
      logic       finish_err;
   } cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic fill_last;
      logic cfg_bad;
      logic rank_ge;
      logic k_zero;
      logic k_one;
   } stat_type;

endpackage

`default_nettype wire

[design/fwwu_ram.sv]
// Generic simple dual-port RAM with registered read.
`default_nettype none

module fwwu_ram #(
   parameter int WIDTH  = 8,
   parameter int DEPTH  = 16,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              we,
   input  logic [ADDR_W-1:0] waddr,
   input  logic [WIDTH-1:0]  wdata,
   input  logic [ADDR_W-1:0] raddr,
   output logic [WIDTH-1:0]  rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write one entry, read one entry per cycle
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

[design/fwwu_ctrl.sv]
// Controller state machine for the fixed-weight word unrank block.
`default_nettype none

module fwwu_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   output fwwu_pkg::cmd_type  cmd,
   input  fwwu_pkg::stat_type stat
);
   import fwwu_pkg::*;

   localparam logic [1:0] ST_FILL  = 2'd0;
   localparam logic [1:0] ST_IDLE  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_SCAN  = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   // Sequence table fill, range check and row scan
   always_comb begin
      cmd          = '0;
      cmd.addr_sel = ADDR_RANGE;
      state_in     = state_ff;
      unique case (state_ff)
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (stat.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               if (stat.cfg_bad) begin
                  cmd.finish_err = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  state_in = ST_RANGE;
               end
            end
         end
         ST_RANGE: begin
            cmd.addr_sel = ADDR_START;
            if (stat.rank_ge) begin
               cmd.finish_err = 1'b1;
               state_in       = ST_IDLE;
            end else if (stat.k_zero) begin
               cmd.finish_ok = 1'b1;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.scan     = 1'b1;
            cmd.addr_sel = ADDR_SCAN;
            if (stat.rank_ge && stat.k_one) begin
               cmd.finish_ok = 1'b1;
               state_in      = ST_IDLE;
            end
         end
      endcase
   end

   // Hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_FILL;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

[design/fwwu_dp.sv]
// Datapath: config registers, binomial table fill, rank scan and result registers.
`default_nettype none

module fwwu_dp #(
   parameter int MAX_WIDTH = fwwu_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [fwwu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fwwu_pkg::CFG_W-1:0]     csr_wdata,
   input  logic [fwwu_pkg::RANK_W-1:0]    req_rank_in,
   input  fwwu_pkg::cmd_type              cmd,
   output fwwu_pkg::stat_type             stat,
   output logic                           rsp_valid,
   output logic [fwwu_pkg::WORD_W-1:0]    rsp_word_out,
   output logic                           rsp_range_error
);
   import fwwu_pkg::*;

   localparam int DIM    = MAX_WIDTH + 1;
   localparam int IDX_W  = $clog2(DIM);
   localparam int ADDR_W = 2 * IDX_W;
   localparam int DEPTH  = 1 << ADDR_W;

   logic [CFG_W-1:0]   word_width_ff;
   logic [CFG_W-1:0]   ones_count_ff;
   logic [IDX_W-1:0]   fill_n_ff;
   logic [IDX_W-1:0]   fill_k_ff;
   logic [ENTRY_W-1:0] row_ff [DIM];
   logic [ENTRY_W-1:0] left_ff;
   logic [ENTRY_W-1:0] row_old;
   logic [ENTRY_W:0]   fill_sum;
   logic [ENTRY_W-1:0] fill_val;
   logic [ADDR_W-1:0]  raddr;
   logic [ENTRY_W-1:0] rd_data;
   logic [RANK_W-1:0]  rank_ff;
   logic [RANK_W-1:0]  rank_in;
   logic [WORD_W-1:0]  word_ff;
   logic [WORD_W-1:0]  word_in;
   logic [IDX_W-1:0]   m_ff;
   logic [IDX_W-1:0]   m_in;
   logic [IDX_W-1:0]   m_dec;
   logic [IDX_W-1:0]   k_ff;
   logic [IDX_W-1:0]   k_in;
   logic [IDX_W-1:0]   k_next;
   logic               rank_ge;
   logic               hit;
   logic               valid_ff;
   logic [WORD_W-1:0]  word_out_ff;
   logic               error_ff;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         word_width_ff <= WORD_WIDTH_RST;
         ones_count_ff <= ONES_COUNT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_WORD_WIDTH: word_width_ff <= csr_wdata;
            REG_ONES_COUNT: ones_count_ff <= csr_wdata;
         endcase
      end
   end

   // Build the next Pascal entry from the row buffer
   always_comb begin
      row_old  = row_ff[fill_k_ff];
      fill_sum = {1'b0, left_ff} + {1'b0, row_old};
      if (fill_n_ff == '0) begin
         fill_val = (fill_k_ff == '0) ? ENTRY_W'(1) : '0;
      end else if (fill_k_ff == '0) begin
         fill_val = ENTRY_W'(1);
      end else begin
         fill_val = fill_sum[ENTRY_W-1:0];
      end
   end

   // Advance the fill position, row by row
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_n_ff <= '0;
         fill_k_ff <= '0;
      end else if (cmd.fill_step) begin
         if (fill_k_ff == IDX_W'(MAX_WIDTH)) begin
            fill_k_ff <= '0;
            fill_n_ff <= fill_n_ff + 1'b1;
         end else begin
            fill_k_ff <= fill_k_ff + 1'b1;
         end
      end
   end

   // Update the row buffer in place, keeping the overwritten left neighbor
   always_ff @(posedge clock) begin
      if (cmd.fill_step) begin
         row_ff[fill_k_ff] <= fill_val;
         left_ff           <= row_old;
      end
   end

   // Select the table read address
   assign hit    = cmd.scan && rank_ge;
   assign m_dec  = m_ff - 1'b1;
   assign k_next = k_ff - IDX_W'(hit);

   always_comb begin
      unique case (cmd.addr_sel)
         ADDR_RANGE: raddr = {word_width_ff[IDX_W-1:0], ones_count_ff[IDX_W-1:0]};
         ADDR_START: raddr = {m_ff, k_ff};
         ADDR_SCAN:  raddr = {m_dec, k_next};
         default:    raddr = {word_width_ff[IDX_W-1:0], ones_count_ff[IDX_W-1:0]};
      endcase
   end

   fwwu_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (DEPTH)
   ) u_table (
      .clock (clock),
      .we    (cmd.fill_step),
      .waddr ({fill_n_ff, fill_k_ff}),
      .wdata (fill_val),
      .raddr (raddr),
      .rdata (rd_data)
   );

   // Compare the remaining rank with the entry read last cycle
   assign rank_ge = (rank_ff >= RANK_W'(rd_data));

   // Next rank, word, row and column
   always_comb begin
      rank_in = rank_ff;
      word_in = word_ff;
      m_in    = m_ff;
      k_in    = k_ff;
      if (cmd.load) begin
         rank_in = req_rank_in;
         word_in = '0;
         m_in    = word_width_ff[IDX_W-1:0] - 1'b1;
         k_in    = ones_count_ff[IDX_W-1:0];
      end else if (cmd.scan) begin
         m_in = m_dec;
         k_in = k_next;
         if (hit) begin
            rank_in = rank_ff - RANK_W'(rd_data);
            word_in = word_ff | (WORD_W'(1) << m_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      rank_ff <= rank_in;
      word_ff <= word_in;
      m_ff    <= m_in;
      k_ff    <= k_in;
   end

   // Register the result for one cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cmd.finish_ok || cmd.finish_err;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish_ok || cmd.finish_err) begin
         word_out_ff <= cmd.finish_err ? '0 : word_in;
         error_ff    <= cmd.finish_err;
      end
   end

   // Report status
   assign stat.fill_last = (fill_n_ff == IDX_W'(MAX_WIDTH)) &&
                           (fill_k_ff == IDX_W'(MAX_WIDTH));
   assign stat.cfg_bad   = (word_width_ff > CFG_W'(MAX_WIDTH)) ||
                           (ones_count_ff > word_width_ff);
   assign stat.rank_ge   = rank_ge;
   assign stat.k_zero    = (k_ff == '0);
   assign stat.k_one     = (k_ff == IDX_W'(1));

   assign rsp_valid       = valid_ff;
   assign rsp_word_out    = word_out_ff;
   assign rsp_range_error = error_ff;

endmodule

`default_nettype wire

[design/fixed_weight_word_unrank.sv]
// Top level of the fixed-weight word unrank block.
//
//   Channel   Ports                                  Handshake
//   request   req_rank_in                            start && !busy
//   response  rsp_word_out, rsp_range_error          rsp_valid, one-cycle strobe
//   csr       csr_index, csr_wdata                   csr_we, no wait
//
// After reset the block fills its binomial RAM with busy high; csr writes are
// taken during that time. A request with a bad configuration returns its
// strobe the next cycle. Otherwise the scan walks down one table row per cycle
// through the RAM's registered read port, and busy falls in the cycle the
// strobe is shown.
// The receiver cannot stall; each result is shown for exactly one cycle.
`default_nettype none
`include "fixed_weight_word_unrank_macros.svh"

module fixed_weight_word_unrank #(
   parameter int MAX_WIDTH = fwwu_pkg::MAX_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  logic [fwwu_pkg::RANK_W-1:0]    req_rank_in,
   output logic                           rsp_valid,
   output logic [fwwu_pkg::WORD_W-1:0]    rsp_word_out,
   output logic                           rsp_range_error,
   input  logic                           csr_we,
   input  logic [fwwu_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fwwu_pkg::CFG_W-1:0]     csr_wdata
);
   import fwwu_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   fwwu_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd),
      .stat  (stat)
   );

   fwwu_dp #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_rank_in     (req_rank_in),
      .cmd             (cmd),
      .stat            (stat),
      .rsp_valid       (rsp_valid),
      .rsp_word_out    (rsp_word_out),
      .rsp_range_error (rsp_range_error)
   );

   // An error result carries an empty word
   `FWWU_ASSERT_SAME(a_err_word_zero, rsp_valid && rsp_range_error, rsp_word_out == '0, "error result with nonzero word")

   // An accepted request either starts work or answers at once
   `FWWU_ASSERT_NEXT(a_req_progress, start && !busy, busy || rsp_valid, "accepted request dropped")

   // A result is only shown once the controller is back to idle
   `FWWU_ASSERT_SAME(a_rsp_idle, rsp_valid, !busy, "result shown while busy")

endmodule

`default_nettype wire
